// ----- src/graph_edge_table_degree_hash_unit_assert.svh -----
// Assertion macros for the graph edge table checker.
// Depends on a clock named clk and a reset named rst in the using scope.
`ifndef GRAPH_EDGE_TABLE_DEGREE_HASH_UNIT_ASSERT_SVH
`define GRAPH_EDGE_TABLE_DEGREE_HASH_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define GEDH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define GEDH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, active during reset
`define GEDH_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/gedh_pkg.sv -----
// Shared constants, codes and controller/datapath command type
// for the graph edge table degree hash unit. No dependencies.
package gedh_pkg;

  localparam int VID_W = 5;
  localparam int DEG_W = 6;
  localparam int CNT_W = 6;
  localparam int ROW_W = 2 ** VID_W;
  localparam int SUM_W = 32;
  localparam int HASH_W = 31;

  localparam logic [CNT_W-1:0] VERTEX_LIMIT = 6'd32;
  localparam logic [CNT_W-1:0] CAPACITY_RESET = 6'd32;
  localparam logic [CNT_W-1:0] START_RESET = 6'd0;

  localparam logic [1:0] ACT_ADD_EDGE = 2'd0;
  localparam logic [1:0] ACT_REMOVE_EDGE = 2'd1;
  localparam logic [1:0] ACT_ADD_VERTEX = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_START = 1'b1;

  typedef struct packed {
    logic accept_edge;
    logic accept_simple;
    logic rd_t;
    logic cap_f;
    logic cap_t;
    logic calc;
    logic wr_f;
    logic wr_t;
  } cmd_t;

endpackage

// ----- src/gedh_ctrl.sv -----
// Sequencer for the graph edge table: accepts transactions and steps the
// datapath through read, compute and write-back. Depends on gedh_pkg.
module gedh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        action,
  input  logic              edge_ok,
  output logic              busy,
  output logic              done,
  output gedh_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDF  = 3'd1;
  localparam logic [2:0] S_RDT  = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_WRF  = 3'd4;
  localparam logic [2:0] S_WRT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;
  logic       is_edge;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign is_edge = (action == gedh_pkg::ACT_ADD_EDGE) ||
                   (action == gedh_pkg::ACT_REMOVE_EDGE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_edge && edge_ok) begin
            cmd.accept_edge = 1'b1;
            state_next = S_RDF;
          end else begin
            cmd.accept_simple = 1'b1;
          end
        end
      end
      S_RDF: begin
        cmd.cap_f = 1'b1;
        cmd.rd_t = 1'b1;
        state_next = S_RDT;
      end
      S_RDT: begin
        cmd.cap_t = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        state_next = S_WRF;
      end
      S_WRF: begin
        cmd.wr_f = 1'b1;
        state_next = S_WRT;
      end
      S_WRT: begin
        cmd.wr_t = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= cmd.accept_simple || cmd.wr_t;
    end
  end

endmodule

// ----- src/gedh_dp.sv -----
// Datapath for the graph edge table: row/degree memory, cube sum,
// vertex count and result registers. Depends on gedh_pkg.
module gedh_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  gedh_pkg::cmd_t                         cmd,
  input  logic [1:0]                             action,
  input  logic [gedh_pkg::VID_W-1:0]             from_vertex,
  input  logic [gedh_pkg::VID_W-1:0]             to_vertex,
  input  logic [gedh_pkg::CNT_W-1:0]             cap_now,
  input  logic [gedh_pkg::CNT_W-1:0]             start_vertices,
  output logic                                   edge_ok,
  output logic                                   status,
  output logic                                   edge_was_present,
  output logic [gedh_pkg::DEG_W-1:0]             first_degree,
  output logic [gedh_pkg::DEG_W-1:0]             second_degree,
  output logic [gedh_pkg::CNT_W-1:0]             vertex_count,
  output logic signed [gedh_pkg::HASH_W-1:0]     hash_value
);

  localparam int ENT_W = gedh_pkg::DEG_W + gedh_pkg::ROW_W;
  localparam int STEP_W = 14;

  // entry = {degree, adjacency row}
  logic [ENT_W-1:0]              mem [gedh_pkg::ROW_W];
  logic [gedh_pkg::ROW_W-1:0]    valid;
  logic [ENT_W-1:0]              rd_data;
  logic                          rd_valid;
  logic [gedh_pkg::VID_W-1:0]    rd_addr;
  logic                          we;
  logic [gedh_pkg::VID_W-1:0]    wr_addr;
  logic [ENT_W-1:0]              wr_data;
  logic [ENT_W-1:0]              rd_entry;

  logic [gedh_pkg::VID_W-1:0]    f_reg;
  logic [gedh_pkg::VID_W-1:0]    t_reg;
  logic                          inc;
  logic [gedh_pkg::ROW_W-1:0]    row_f;
  logic [gedh_pkg::ROW_W-1:0]    row_t;
  logic [gedh_pkg::DEG_W-1:0]    deg_f;
  logic [gedh_pkg::DEG_W-1:0]    deg_t;
  logic [gedh_pkg::ROW_W-1:0]    new_row_f;
  logic [gedh_pkg::ROW_W-1:0]    new_row_t;
  logic [gedh_pkg::DEG_W-1:0]    new_deg_f;
  logic [gedh_pkg::DEG_W-1:0]    new_deg_t;
  logic                          was;
  logic [gedh_pkg::SUM_W-1:0]    delta;

  logic [gedh_pkg::SUM_W-1:0]    cube_sum;
  logic [gedh_pkg::CNT_W-1:0]    live;
  logic [gedh_pkg::SUM_W-1:0]    hash_round;

  logic                          c_was;
  logic                          c_flip;
  logic [gedh_pkg::DEG_W-1:0]    c_amt;
  logic [STEP_W:0]               c_mag;
  logic [gedh_pkg::SUM_W-1:0]    c_mag_ext;
  logic [gedh_pkg::ROW_W-1:0]    f_bit;
  logic [gedh_pkg::ROW_W-1:0]    t_bit;

  // |cube(d +- 1) - cube(d)| = 3d^2 +- 3d + 1
  function automatic logic [STEP_W-1:0] cube_step(input logic [gedh_pkg::DEG_W-1:0] d,
                                                  input logic up);
    logic [11:0]        sq;
    logic [STEP_W-1:0]  three_sq;
    logic [STEP_W-1:0]  three_d;
    sq = {6'b0, d} * {6'b0, d};
    three_sq = {1'b0, sq, 1'b0} + {2'b0, sq};
    three_d = {7'b0, d, 1'b0} + {8'b0, d};
    if (up) begin
      cube_step = three_sq + three_d + 14'd1;
    end else begin
      cube_step = three_sq - three_d + 14'd1;
    end
  endfunction

  assign edge_ok = ({1'b0, from_vertex} < live) && ({1'b0, to_vertex} < live);

  assign rd_addr = cmd.rd_t ? t_reg : from_vertex;
  assign rd_entry = rd_valid ? rd_data : '0;
  assign we = cmd.wr_f || cmd.wr_t;
  assign wr_addr = cmd.wr_t ? t_reg : f_reg;
  assign wr_data = cmd.wr_t ? {new_deg_t, new_row_t} : {new_deg_f, new_row_f};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[rd_addr];
      if (cmd.accept_simple && action == gedh_pkg::ACT_CLEAR) begin
        valid <= '0;
      end else if (we) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_comb begin
    f_bit = '0;
    t_bit = '0;
    f_bit[f_reg] = 1'b1;
    t_bit[t_reg] = 1'b1;
    c_was = row_f[t_reg];
    c_flip = inc ? !c_was : c_was;
    c_amt = (f_reg == t_reg) ? 6'd2 : 6'd1;
    c_mag = {1'b0, cube_step(deg_f, inc)} + {1'b0, cube_step(deg_t, inc)};
    c_mag_ext = {{(gedh_pkg::SUM_W-STEP_W-1){1'b0}}, c_mag};
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_edge) begin
      f_reg <= from_vertex;
      t_reg <= to_vertex;
      inc <= (action == gedh_pkg::ACT_ADD_EDGE);
    end
    if (cmd.cap_f) begin
      row_f <= rd_entry[gedh_pkg::ROW_W-1:0];
      deg_f <= rd_entry[ENT_W-1:gedh_pkg::ROW_W];
    end
    if (cmd.cap_t) begin
      row_t <= rd_entry[gedh_pkg::ROW_W-1:0];
      deg_t <= rd_entry[ENT_W-1:gedh_pkg::ROW_W];
    end
    if (cmd.calc) begin
      was <= c_was;
      new_row_f <= inc ? (row_f | t_bit) : (row_f & ~t_bit);
      new_row_t <= inc ? (row_t | f_bit) : (row_t & ~f_bit);
      if (c_flip) begin
        new_deg_f <= inc ? deg_f + c_amt : deg_f - c_amt;
        new_deg_t <= inc ? deg_t + c_amt : deg_t - c_amt;
        delta <= inc ? c_mag_ext : -c_mag_ext;
      end else begin
        new_deg_f <= deg_f;
        new_deg_t <= deg_t;
        delta <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cube_sum <= '0;
      live <= '0;
    end else if (cmd.wr_t) begin
      cube_sum <= cube_sum + delta;
    end else if (cmd.accept_simple) begin
      if (action == gedh_pkg::ACT_CLEAR) begin
        cube_sum <= '0;
        live <= (start_vertices < cap_now) ? start_vertices : cap_now;
      end else if (action == gedh_pkg::ACT_ADD_VERTEX && live < cap_now) begin
        live <= live + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_t) begin
      status <= gedh_pkg::STATUS_DONE;
      edge_was_present <= was;
      first_degree <= new_deg_f;
      second_degree <= new_deg_t;
    end else if (cmd.accept_simple) begin
      edge_was_present <= 1'b0;
      first_degree <= '0;
      second_degree <= '0;
      priority if (action == gedh_pkg::ACT_ADD_VERTEX) begin
        status <= (live < cap_now) ? gedh_pkg::STATUS_DONE : gedh_pkg::STATUS_REFUSED;
      end else if (action == gedh_pkg::ACT_CLEAR) begin
        status <= gedh_pkg::STATUS_DONE;
      end else begin
        status <= gedh_pkg::STATUS_REFUSED;
      end
    end
  end

  // signed halving, truncated toward zero
  assign hash_round = cube_sum + {{(gedh_pkg::SUM_W-1){1'b0}}, cube_sum[gedh_pkg::SUM_W-1]};
  assign hash_value = hash_round[gedh_pkg::SUM_W-1:1];
  assign vertex_count = live;

endmodule

// ----- src/graph_edge_table_degree_hash_unit.sv -----
// Graph edge table with degree-cube hash: configuration registers and
// controller/datapath wiring. Depends on gedh_pkg, gedh_ctrl, gedh_dp.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   action selects add edge, remove edge, add vertex or clear; from_vertex
//   and to_vertex name the endpoints of edge actions.
//   Each transaction yields one result, shown for one cycle with done high.
//   Add vertex, clear and refused edge actions: result in the next cycle.
//   Accepted edge actions: busy is high through RDF, RDT, CALC, WRF and WRT; done follows WRT.
//   The edge path reads two rows of the row/degree memory (one read port, one write port) one
//   at a time, computes cube steps, then writes the two rows back in turn.
//   busy is low while done is high, so a new start may coincide with a result.
//   Throughput: 1 per cycle for non-edge actions while no edge action holds busy high.
//   The receiver cannot stall; done is a one-cycle strobe.
//   Registers over APB: 0x0 vertex_capacity (reset 32), 0x4 start_vertices
//   (reset 0); write only while idle. pready is always high.
//   Synchronous reset empties the graph (row valid bits cleared at once),
//   zeroes the vertex count and hash, and restores register defaults.
module graph_edge_table_degree_hash_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           action,
  input  logic [gedh_pkg::VID_W-1:0]           from_vertex,
  input  logic [gedh_pkg::VID_W-1:0]           to_vertex,
  output logic                                 done,
  output logic                                 status,
  output logic                                 edge_was_present,
  output logic [gedh_pkg::DEG_W-1:0]           first_degree,
  output logic [gedh_pkg::DEG_W-1:0]           second_degree,
  output logic [gedh_pkg::CNT_W-1:0]           vertex_count,
  output logic signed [gedh_pkg::HASH_W-1:0]   hash_value,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [gedh_pkg::CNT_W-1:0] vertex_capacity;
  logic [gedh_pkg::CNT_W-1:0] start_vertices;
  logic [gedh_pkg::CNT_W-1:0] cap_now;
  logic                       cfg_wr;
  logic                       edge_ok;
  gedh_pkg::cmd_t             cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == gedh_pkg::REG_START) ? {26'b0, start_vertices}
                                                    : {26'b0, vertex_capacity};
  assign cap_now = (vertex_capacity < gedh_pkg::VERTEX_LIMIT) ? vertex_capacity
                                                              : gedh_pkg::VERTEX_LIMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_capacity <= gedh_pkg::CAPACITY_RESET;
      start_vertices <= gedh_pkg::START_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        gedh_pkg::REG_CAPACITY: vertex_capacity <= pwdata[gedh_pkg::CNT_W-1:0];
        gedh_pkg::REG_START:    start_vertices <= pwdata[gedh_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  gedh_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .action  (action),
    .edge_ok (edge_ok),
    .busy    (busy),
    .done    (done),
    .cmd     (cmd)
  );

  gedh_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .action           (action),
    .from_vertex      (from_vertex),
    .to_vertex        (to_vertex),
    .cap_now          (cap_now),
    .start_vertices   (start_vertices),
    .edge_ok          (edge_ok),
    .status           (status),
    .edge_was_present (edge_was_present),
    .first_degree     (first_degree),
    .second_degree    (second_degree),
    .vertex_count     (vertex_count),
    .hash_value       (hash_value)
  );

endmodule

// ----- src/gedh_checker.sv -----
// Port-level checks for the graph edge table unit, bound to the top level.
// Depends on graph_edge_table_degree_hash_unit_assert.svh.
`include "graph_edge_table_degree_hash_unit_assert.svh"

module gedh_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       status,
  input logic       edge_was_present,
  input logic [5:0] first_degree,
  input logic [5:0] second_degree,
  input logic [5:0] vertex_count
);

  `GEDH_ASSERT_RST(a_reset_idle, rst, !busy && !done, "not idle after reset")
  `GEDH_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy, "transaction dropped")
  `GEDH_ASSERT_NOW(a_done_idle, done, !busy, "result while busy")
  `GEDH_ASSERT_NOW(a_refused_zero, done && status,
                   !edge_was_present && first_degree == 6'd0 && second_degree == 6'd0,
                   "refused result carries edge data")
  `GEDH_ASSERT_NOW(a_count_range, done, vertex_count <= 6'd32, "vertex count out of range")

endmodule

bind graph_edge_table_degree_hash_unit gedh_checker u_gedh_checker (.*);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for graph_edge_table_degree_hash_unit.
// Directed rows and weighted random actions are checked against a predictor of the graph
// store, or against fixed expected results for rows built with chk_row. Depends on gedh_pkg and the unit under test.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 136;

  typedef struct packed {
    logic                        status;
    logic                        was;
    logic [gedh_pkg::DEG_W-1:0]  fd;
    logic [gedh_pkg::DEG_W-1:0]  td;
    logic [gedh_pkg::CNT_W-1:0]  vc;
    logic [gedh_pkg::HASH_W-1:0] hash;
  } graph_result_t;

  typedef struct {
    bit                          cfg;
    logic [gedh_pkg::CNT_W-1:0]  cap_v;
    logic [gedh_pkg::CNT_W-1:0]  start_v;
    logic [1:0]                  act;
    logic [gedh_pkg::VID_W-1:0]  f;
    logic [gedh_pkg::VID_W-1:0]  t;
    bit                          typed;
    graph_result_t               want;
  } step_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] action;
  logic [gedh_pkg::VID_W-1:0] from_vertex;
  logic [gedh_pkg::VID_W-1:0] to_vertex;
  logic done;
  logic status;
  logic edge_was_present;
  logic [gedh_pkg::DEG_W-1:0] first_degree;
  logic [gedh_pkg::DEG_W-1:0] second_degree;
  logic [gedh_pkg::CNT_W-1:0] vertex_count;
  logic signed [gedh_pkg::HASH_W-1:0] hash_value;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  graph_edge_table_degree_hash_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .from_vertex(from_vertex), .to_vertex(to_vertex), .done(done), .status(status),
    .edge_was_present(edge_was_present), .first_degree(first_degree),
    .second_degree(second_degree), .vertex_count(vertex_count), .hash_value(hash_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the graph store
  logic [gedh_pkg::ROW_W-1:0] adj [gedh_pkg::ROW_W];
  logic [gedh_pkg::DEG_W-1:0] deg [gedh_pkg::ROW_W];
  logic [gedh_pkg::SUM_W-1:0] csum;
  logic [gedh_pkg::CNT_W-1:0] live;
  logic [gedh_pkg::CNT_W-1:0] cap_reg;
  logic [gedh_pkg::CNT_W-1:0] start_reg;

  graph_result_t pending_results[$];
  step_t dir_rows[$];
  int errors;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [gedh_pkg::SUM_W-1:0] cube(input logic [gedh_pkg::SUM_W-1:0] x);
    return x * x * x;
  endfunction

  function automatic void clear_graph();
    for (int i = 0; i < gedh_pkg::ROW_W; i++) begin
      adj[i] = '0;
      deg[i] = '0;
    end
    csum = '0;
  endfunction

  function automatic graph_result_t apply_graph_action(input logic [1:0] act,
                                                       input logic [gedh_pkg::VID_W-1:0] f,
                                                       input logic [gedh_pkg::VID_W-1:0] t);
    graph_result_t r;
    logic [gedh_pkg::SUM_W-1:0] df;
    logic [gedh_pkg::SUM_W-1:0] dt;
    logic [gedh_pkg::CNT_W-1:0] capn;
    logic was;
    int s;
    r = '0;
    capn = (cap_reg < gedh_pkg::VERTEX_LIMIT) ? cap_reg : gedh_pkg::VERTEX_LIMIT;
    if (act == gedh_pkg::ACT_ADD_EDGE || act == gedh_pkg::ACT_REMOVE_EDGE) begin
      if (f >= live || t >= live) begin
        r.status = gedh_pkg::STATUS_REFUSED;
      end else begin
        df = gedh_pkg::SUM_W'(deg[f]);
        dt = gedh_pkg::SUM_W'(deg[t]);
        was = adj[f][t];
        // a self-loop takes both steps on the same vertex
        if (act == gedh_pkg::ACT_ADD_EDGE && !was) begin
          csum = csum + cube(df + 1) - cube(df);
          csum = csum + cube(dt + 1) - cube(dt);
          deg[f] = deg[f] + 1'b1;
          deg[t] = deg[t] + 1'b1;
        end else if (act == gedh_pkg::ACT_REMOVE_EDGE && was) begin
          csum = csum + cube(df - 1) - cube(df);
          csum = csum + cube(dt - 1) - cube(dt);
          deg[f] = deg[f] - 1'b1;
          deg[t] = deg[t] - 1'b1;
        end
        adj[f][t] = (act == gedh_pkg::ACT_ADD_EDGE);
        adj[t][f] = (act == gedh_pkg::ACT_ADD_EDGE);
        r.status = gedh_pkg::STATUS_DONE;
        r.was = was;
        r.fd = deg[f];
        r.td = deg[t];
      end
    end else if (act == gedh_pkg::ACT_ADD_VERTEX) begin
      if (live >= capn) r.status = gedh_pkg::STATUS_REFUSED;
      else live = live + 1'b1;
    end else begin
      clear_graph();
      live = (start_reg < capn) ? start_reg : capn;
    end
    r.vc = live;
    s = int'(signed'(csum)) / 2;
    r.hash = s[gedh_pkg::HASH_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    graph_result_t got;
    graph_result_t want;
    if (!rst && done) begin
      got.status = status;
      got.was = edge_was_present;
      got.fd = first_degree;
      got.td = second_degree;
      got.vc = vertex_count;
      got.hash = hash_value;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch st %b/%b was %b/%b fd %0d/%0d td %0d/%0d vc %0d/%0d hash %0d/%0d",
                     want.status, got.status, want.was, got.was, want.fd, got.fd,
                     want.td, got.td, want.vc, got.vc,
                     $signed(want.hash), $signed(got.hash));
        end
      end
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [gedh_pkg::CNT_W-1:0] val);
    wait_idle();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = 32'(val);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == gedh_pkg::REG_CAPACITY) cap_reg = val;
    else start_reg = val;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic issue(input logic [1:0] act, input logic [gedh_pkg::VID_W-1:0] f,
                       input logic [gedh_pkg::VID_W-1:0] t, input int gap, input bit typed,
                       input graph_result_t want);
    graph_result_t res;
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    action = act;
    from_vertex = f;
    to_vertex = t;
    do @(posedge clk); while (busy);
    res = apply_graph_action(act, f, t);
    pending_results.push_back(typed ? want : res);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(24, 5);
  endfunction

  function automatic step_t it_row(input logic [1:0] act,
                                   input logic [gedh_pkg::VID_W-1:0] f,
                                   input logic [gedh_pkg::VID_W-1:0] t);
    step_t s;
    s = '{default: '0};
    s.act = act;
    s.f = f;
    s.t = t;
    return s;
  endfunction

  function automatic step_t chk_row(input logic [1:0] act,
                                    input logic [gedh_pkg::VID_W-1:0] f,
                                    input logic [gedh_pkg::VID_W-1:0] t, input logic st,
                                    input logic was, input int fd, input int td,
                                    input int vc, input int hash);
    step_t s;
    s = it_row(act, f, t);
    s.typed = 1'b1;
    s.want.status = st;
    s.want.was = was;
    s.want.fd = gedh_pkg::DEG_W'(fd);
    s.want.td = gedh_pkg::DEG_W'(td);
    s.want.vc = gedh_pkg::CNT_W'(vc);
    s.want.hash = gedh_pkg::HASH_W'(hash);
    return s;
  endfunction

  function automatic step_t cfg_row(input int cap_v, input int start_v);
    step_t s;
    s = '{default: '0};
    s.cfg = 1'b1;
    s.cap_v = gedh_pkg::CNT_W'(cap_v);
    s.start_v = gedh_pkg::CNT_W'(start_v);
    return s;
  endfunction

  initial begin : stimulus
    logic [gedh_pkg::CNT_W-1:0] phase_cap [PHASES];
    logic [gedh_pkg::CNT_W-1:0] phase_start [PHASES];
    logic [1:0] act;
    logic [gedh_pkg::VID_W-1:0] f;
    logic [gedh_pkg::VID_W-1:0] t;
    int r;
    int gap;
    step_t s;

    rst = 1'b1;
    start = 1'b0;
    action = gedh_pkg::ACT_ADD_EDGE;
    from_vertex = '0;
    to_vertex = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    cycles = 0;
    clear_graph();
    live = '0;
    cap_reg = gedh_pkg::CAPACITY_RESET;
    start_reg = gedh_pkg::START_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    dir_rows.push_back(chk_row(gedh_pkg::ACT_ADD_EDGE, 0, 0, gedh_pkg::STATUS_REFUSED,
                               0, 0, 0, 0, 0));
    dir_rows.push_back(chk_row(gedh_pkg::ACT_REMOVE_EDGE, 31, 31, gedh_pkg::STATUS_REFUSED,
                               0, 0, 0, 0, 0));
    dir_rows.push_back(chk_row(gedh_pkg::ACT_ADD_VERTEX, 0, 0, gedh_pkg::STATUS_DONE,
                               0, 0, 0, 1, 0));
    dir_rows.push_back(chk_row(gedh_pkg::ACT_ADD_VERTEX, 31, 31, gedh_pkg::STATUS_DONE,
                               0, 0, 0, 2, 0));
    dir_rows.push_back(chk_row(gedh_pkg::ACT_ADD_EDGE, 0, 1, gedh_pkg::STATUS_DONE,
                               0, 1, 1, 2, 1));
    dir_rows.push_back(chk_row(gedh_pkg::ACT_ADD_EDGE, 1, 0, gedh_pkg::STATUS_DONE,
                               1, 1, 1, 2, 1));
    dir_rows.push_back(it_row(gedh_pkg::ACT_ADD_EDGE, 1, 1));
    dir_rows.push_back(it_row(gedh_pkg::ACT_REMOVE_EDGE, 1, 1));
    dir_rows.push_back(it_row(gedh_pkg::ACT_REMOVE_EDGE, 0, 1));
    dir_rows.push_back(it_row(gedh_pkg::ACT_REMOVE_EDGE, 1, 0));
    dir_rows.push_back(it_row(gedh_pkg::ACT_ADD_EDGE, 2, 0));
    dir_rows.push_back(it_row(gedh_pkg::ACT_ADD_EDGE, 0, 2));
    dir_rows.push_back(chk_row(gedh_pkg::ACT_CLEAR, 0, 0, gedh_pkg::STATUS_DONE,
                               0, 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(1, 32));
    dir_rows.push_back(chk_row(gedh_pkg::ACT_CLEAR, 0, 0, gedh_pkg::STATUS_DONE,
                               0, 0, 0, 1, 0));
    dir_rows.push_back(chk_row(gedh_pkg::ACT_ADD_VERTEX, 0, 0, gedh_pkg::STATUS_REFUSED,
                               0, 0, 0, 1, 0));
    dir_rows.push_back(it_row(gedh_pkg::ACT_ADD_EDGE, 0, 0));
    dir_rows.push_back(it_row(gedh_pkg::ACT_ADD_EDGE, 0, 1));
    dir_rows.push_back(cfg_row(32, 32));
    dir_rows.push_back(it_row(gedh_pkg::ACT_ADD_VERTEX, 0, 0));
    dir_rows.push_back(chk_row(gedh_pkg::ACT_CLEAR, 31, 31, gedh_pkg::STATUS_DONE,
                               0, 0, 0, 32, 0));
    dir_rows.push_back(chk_row(gedh_pkg::ACT_ADD_VERTEX, 0, 0, gedh_pkg::STATUS_REFUSED,
                               0, 0, 0, 32, 0));
    dir_rows.push_back(it_row(gedh_pkg::ACT_ADD_EDGE, 31, 31));
    dir_rows.push_back(it_row(gedh_pkg::ACT_ADD_EDGE, 31, 0));
    dir_rows.push_back(it_row(gedh_pkg::ACT_REMOVE_EDGE, 0, 31));
    dir_rows.push_back(it_row(gedh_pkg::ACT_ADD_EDGE, 21, 10));
    // capacity dropped under the live count
    dir_rows.push_back(cfg_row(4, 0));
    dir_rows.push_back(it_row(gedh_pkg::ACT_ADD_VERTEX, 0, 0));
    dir_rows.push_back(it_row(gedh_pkg::ACT_ADD_EDGE, 30, 29));
    dir_rows.push_back(it_row(gedh_pkg::ACT_CLEAR, 0, 0));

    foreach (dir_rows[i]) begin
      s = dir_rows[i];
      if (s.cfg) begin
        apb_write(gedh_pkg::REG_CAPACITY, s.cap_v);
        apb_write(gedh_pkg::REG_START, s.start_v);
      end else begin
        issue(s.act, s.f, s.t, i % 3, s.typed, s.want);
      end
    end

    phase_cap = '{6'd32, 6'd32, 6'd8, 6'd32, 6'd2, 6'd32, 6'd12, 6'd31};
    phase_start = '{6'd32, 6'd6, 6'd3, 6'd32, 6'd2, 6'd0, 6'd32, 6'd20};
    for (int p = 0; p < PHASES; p++) begin
      apb_write(gedh_pkg::REG_CAPACITY, phase_cap[p]);
      apb_write(gedh_pkg::REG_START, phase_start[p]);
      issue(gedh_pkg::ACT_CLEAR, '0, '0, 0, 1'b0, '0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(99);
        f = gedh_pkg::VID_W'($urandom_range(31));
        t = gedh_pkg::VID_W'($urandom_range(31));
        if (r < 70 && live > 0) begin
          act = (r < 45) ? gedh_pkg::ACT_ADD_EDGE : gedh_pkg::ACT_REMOVE_EDGE;
          f = ($urandom_range(3) == 0) ? '0 : gedh_pkg::VID_W'($urandom_range(int'(live) - 1));
          t = gedh_pkg::VID_W'($urandom_range(int'(live) - 1));
        end else if (r < 82) begin
          act = ($urandom_range(1) == 0) ? gedh_pkg::ACT_ADD_EDGE : gedh_pkg::ACT_REMOVE_EDGE;
        end else if (r < 94) begin
          act = gedh_pkg::ACT_ADD_VERTEX;
        end else if (r < 97) begin
          act = gedh_pkg::ACT_CLEAR;
        end else begin
          act = 2'($urandom_range(3));
        end
        gap = (p == 3) ? 0 : pick_gap();
        if ($urandom_range(99) == 0) wait_idle();
        issue(act, f, t, gap, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/gedh_pkg.sv
src/gedh_ctrl.sv
src/gedh_dp.sv
src/graph_edge_table_degree_hash_unit.sv
src/gedh_checker.sv
tb/sv/tb.sv
